@@ hw/rtl/wdq_pkg.sv @@
// Package for the weighted deque: sizes, operation and error codes, item types
// and the command/status structs between controller and datapath. No dependencies.
package wdq_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 16;
    localparam int PTR_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = VALUE_BITS + CNT_W;
    localparam int PROD_W     = VALUE_BITS + CNT_W + 1;
    localparam int WEIGHT_W   = 28;

    localparam logic [1:0] OP_QUERY     = 2'd0;
    localparam logic [1:0] OP_PUSH      = 2'd1;
    localparam logic [1:0] OP_POP_FRONT = 2'd2;
    localparam logic [1:0] OP_POP_BACK  = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]         popped_value;
        logic                       popped_valid;
        logic                       is_empty;
        logic [6:0]                 entry_count;
        logic signed [WEIGHT_W-1:0] weight;
        logic [1:0]                 error;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop_step;
        logic pop_back_finish;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_read;
        logic pop_back;
    } t_dp_status;

endpackage

@@ hw/rtl/wdq_datapath.sv @@
// Datapath of the weighted deque: entry memory, pointers, running sums and the
// output register. Depends on wdq_pkg; driven by wdq_ctrl through t_dp_cmd.
module wdq_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wdq_pkg::t_in_item   i_in_data,
    input  wdq_pkg::t_dp_cmd    i_cmd,
    output wdq_pkg::t_dp_status o_status,
    output wdq_pkg::t_out_item  o_out_data
);

    logic [wdq_pkg::VALUE_BITS-1:0]        r_mem [wdq_pkg::CAPACITY];

    logic [1:0]                            r_op;
    logic signed [15:0]                    r_value;
    logic [wdq_pkg::PTR_W-1:0]             r_fp;
    logic [wdq_pkg::CNT_W-1:0]             r_count;
    logic signed [wdq_pkg::SUM_W-1:0]      r_vsum;
    logic signed [wdq_pkg::WEIGHT_W-1:0]   r_weight;
    logic [1:0]                            r_err;
    logic                                  r_pvalid;
    logic signed [wdq_pkg::VALUE_BITS-1:0] r_popped;
    logic signed [wdq_pkg::VALUE_BITS-1:0] r_rd_data;
    logic signed [wdq_pkg::PROD_W-1:0]     r_prod;
    wdq_pkg::t_out_item                    r_out;

    logic                                  is_empty_c;
    logic                                  is_full_c;
    logic [wdq_pkg::PTR_W-1:0]             fp_dec;
    logic [wdq_pkg::PTR_W-1:0]             fp_inc;
    logic [wdq_pkg::PTR_W:0]               back_sum;
    logic [wdq_pkg::PTR_W-1:0]             back_idx;
    logic [wdq_pkg::PTR_W-1:0]             rd_addr;
    logic signed [wdq_pkg::VALUE_BITS-1:0] v_push;
    logic signed [wdq_pkg::SUM_W-1:0]      v_push_ext;
    logic signed [wdq_pkg::SUM_W-1:0]      rd_ext;
    logic signed [wdq_pkg::SUM_W-1:0]      popped_ext;
    logic signed [wdq_pkg::PROD_W-1:0]     prod_c;
    logic                                  last_entry;

    assign is_empty_c = (r_count == '0);
    assign is_full_c  = (r_count == wdq_pkg::CNT_W'(wdq_pkg::CAPACITY));
    assign last_entry = (r_count == wdq_pkg::CNT_W'(1));

    assign fp_dec = (r_fp == '0) ? wdq_pkg::PTR_W'(wdq_pkg::CAPACITY - 1)
                                 : r_fp - wdq_pkg::PTR_W'(1);
    assign fp_inc = (r_fp == wdq_pkg::PTR_W'(wdq_pkg::CAPACITY - 1)) ? '0
                                 : r_fp + wdq_pkg::PTR_W'(1);

    // The back entry sits count-1 places past the front; one conditional
    // subtract folds the ring index back into range.
    assign back_sum = {1'b0, r_fp} + (wdq_pkg::PTR_W + 1)'(r_count)
                      - (wdq_pkg::PTR_W + 1)'(1);
    always_comb begin
        if (back_sum >= (wdq_pkg::PTR_W + 1)'(wdq_pkg::CAPACITY)) begin
            back_idx = wdq_pkg::PTR_W'(back_sum - (wdq_pkg::PTR_W + 1)'(wdq_pkg::CAPACITY));
        end else begin
            back_idx = back_sum[wdq_pkg::PTR_W-1:0];
        end
    end

    assign rd_addr    = (r_op == wdq_pkg::OP_POP_BACK) ? back_idx : r_fp;
    assign v_push     = wdq_pkg::VALUE_BITS'(r_value);
    assign v_push_ext = wdq_pkg::SUM_W'(v_push);
    assign rd_ext     = wdq_pkg::SUM_W'(r_rd_data);
    assign popped_ext = wdq_pkg::SUM_W'(r_popped);
    assign prod_c     = r_rd_data * $signed({1'b0, r_count});

    assign o_status.need_read = ((r_op == wdq_pkg::OP_POP_FRONT) ||
                                 (r_op == wdq_pkg::OP_POP_BACK)) && !is_empty_c;
    assign o_status.pop_back  = (r_op == wdq_pkg::OP_POP_BACK);
    assign o_out_data         = r_out;

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_op == wdq_pkg::OP_PUSH) && !is_full_c) begin
            r_mem[fp_dec] <= v_push;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_data.operation;
            r_value <= i_in_data.value;
        end
        if (i_cmd.pop_step) begin
            r_prod <= prod_c;
        end
        if (i_cmd.load_out) begin
            r_out.popped_value <= 16'(r_popped);
            r_out.popped_valid <= r_pvalid;
            r_out.is_empty     <= is_empty_c;
            r_out.entry_count  <= 7'(r_count);
            r_out.weight       <= r_weight;
            r_out.error        <= r_err;
        end
    end

    // Queue state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp     <= '0;
            r_count  <= '0;
            r_vsum   <= '0;
            r_weight <= '0;
            r_err    <= wdq_pkg::ERR_NONE;
            r_pvalid <= 1'b0;
            r_popped <= '0;
        end else if (i_cmd.exec) begin
            r_popped <= '0;
            r_pvalid <= 1'b0;
            r_err    <= wdq_pkg::ERR_NONE;
            unique case (r_op)
                wdq_pkg::OP_PUSH: begin
                    if (is_full_c) begin
                        r_err <= wdq_pkg::ERR_OVERFLOW;
                    end else begin
                        // Every older entry moves one place deeper.
                        r_fp     <= fp_dec;
                        r_count  <= r_count + wdq_pkg::CNT_W'(1);
                        r_weight <= r_weight + wdq_pkg::WEIGHT_W'(r_vsum + v_push_ext);
                        r_vsum   <= r_vsum + v_push_ext;
                    end
                end
                wdq_pkg::OP_POP_FRONT, wdq_pkg::OP_POP_BACK: begin
                    if (is_empty_c) begin
                        r_err <= wdq_pkg::ERR_UNDERFLOW;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.pop_step) begin
            r_popped <= r_rd_data;
            r_pvalid <= 1'b1;
            if (r_op == wdq_pkg::OP_POP_FRONT) begin
                r_weight <= r_weight - wdq_pkg::WEIGHT_W'(r_vsum);
                r_vsum   <= r_vsum - rd_ext;
                r_count  <= r_count - wdq_pkg::CNT_W'(1);
                r_fp     <= last_entry ? '0 : fp_inc;
            end
        end else if (i_cmd.pop_back_finish) begin
            r_weight <= r_weight - wdq_pkg::WEIGHT_W'(r_prod);
            r_vsum   <= r_vsum - popped_ext;
            r_count  <= r_count - wdq_pkg::CNT_W'(1);
            if (last_entry) begin
                r_fp <= '0;
            end
        end
    end

endmodule

@@ hw/rtl/wdq_ctrl.sv @@
// Controller of the weighted deque: sequences one operation at a time and owns
// both handshakes. Depends on wdq_pkg; drives wdq_datapath through t_dp_cmd.
module wdq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  wdq_pkg::t_dp_status i_status,
    output wdq_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.need_read ? S_READ : S_RESULT;
            end
            S_READ: begin
                o_cmd.pop_step = 1'b1;
                n_state        = i_status.pop_back ? S_MUL : S_RESULT;
            end
            S_MUL: begin
                o_cmd.pop_back_finish = 1'b1;
                n_state               = S_RESULT;
            end
            S_RESULT: begin
                // Wait until the previous result has been transferred.
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/weighted_deque.sv @@
// A bounded double-ended queue of 64 signed 16-bit entries that keeps a running
// positional weight (the sum of each entry times its one-based depth from the front).
// Items are taken one at a time. The result of a query, a push or any rejected
// operation passes from the execute state through the result state to the output
// register; a pop at the front also passes the read state, and a pop at the back
// the read and the multiply state. The extra states are the registered read port
// of the entry memory and, for a pop at the back, the registered depth multiply.
// The next item is taken in the cycle after a result is loaded, even while that
// result still waits to be transferred. Depends on wdq_pkg, wdq_ctrl and wdq_datapath.
module weighted_deque (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wdq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wdq_pkg::t_out_item o_out_data
);

    wdq_pkg::t_dp_cmd    cmd;
    wdq_pkg::t_dp_status status;

    wdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wdq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

@@ verif/weighted_deque_tb.sv @@
// Self-checking testbench for weighted_deque: directed, fill, backpressure and random traffic with
// a predictor of the deque contents, count and positional weight.
// Depends on wdq_pkg and the weighted_deque RTL.
`timescale 1ns / 1ps

module weighted_deque_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    wdq_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_stall = 1'b0;
    wdq_pkg::t_out_item out_data;

    // Predicted deque contents, front at index 0.
    logic signed [15:0] held_values[$];
    longint             value_sum = 0;
    longint             depth_weight = 0;
    wdq_pkg::t_out_item expected_status[$];

    int error_count = 0;
    int cycle_count = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    weighted_deque i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Applies one operation to the predicted deque and returns the status it should report.
    function automatic wdq_pkg::t_out_item apply_operation(input wdq_pkg::t_in_item item);
        wdq_pkg::t_out_item res;
        logic signed [15:0] v;
        longint             depth;
        res = '0;
        res.error = wdq_pkg::ERR_NONE;
        case (item.operation)
            wdq_pkg::OP_PUSH: begin
                if (held_values.size() >= wdq_pkg::CAPACITY) begin
                    res.error = wdq_pkg::ERR_OVERFLOW;
                end else begin
                    v = item.value;
                    // Every older entry moves one place deeper.
                    depth_weight += value_sum + v;
                    value_sum += v;
                    held_values.push_front(v);
                end
            end
            wdq_pkg::OP_POP_FRONT: begin
                if (held_values.size() == 0) begin
                    res.error = wdq_pkg::ERR_UNDERFLOW;
                end else begin
                    v = held_values.pop_front();
                    depth_weight -= value_sum;
                    value_sum -= v;
                    res.popped_value = v;
                    res.popped_valid = 1'b1;
                end
            end
            wdq_pkg::OP_POP_BACK: begin
                if (held_values.size() == 0) begin
                    res.error = wdq_pkg::ERR_UNDERFLOW;
                end else begin
                    depth = held_values.size();
                    v = held_values.pop_back();
                    depth_weight -= longint'(v) * depth;
                    value_sum -= v;
                    res.popped_value = v;
                    res.popped_valid = 1'b1;
                end
            end
            default: ;
        endcase
        res.is_empty = (held_values.size() == 0);
        res.entry_count = 7'(held_values.size());
        res.weight = depth_weight[wdq_pkg::WEIGHT_W-1:0];
        return res;
    endfunction

    // Receiver: random stalls, long hold-offs on request, and result checking.
    always @(posedge clk) begin
        wdq_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_status.size() == 0) begin
                report_mismatch("result transfer with no expected result");
            end else begin
                want = expected_status.pop_front();
                check_field("popped_value", out_data.popped_value, want.popped_value);
                check_field("popped_valid", out_data.popped_valid, want.popped_valid);
                check_field("is_empty", out_data.is_empty, want.is_empty);
                check_field("entry_count", out_data.entry_count, want.entry_count);
                check_field("weight", out_data.weight, want.weight);
                check_field("error", out_data.error, want.error);
            end
        end
        if (hold_served != hold_requests) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // Offers one item after a random gap and records its prediction once transferred.
    task automatic send_item(input logic [1:0] op, input logic signed [15:0] val);
        wdq_pkg::t_in_item item;
        item.operation = op;
        item.value = val;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_status.push_back(apply_operation(item));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        in_idle_pct = 0;
        out_stall_pct = 0;
        send_item(wdq_pkg::OP_QUERY, 16'sh8000);
        send_item(wdq_pkg::OP_POP_FRONT, 16'sh7fff);
        send_item(wdq_pkg::OP_POP_BACK, 16'sh0000);
        send_item(wdq_pkg::OP_PUSH, 16'sh7fff);
        send_item(wdq_pkg::OP_PUSH, 16'sh8000);
        send_item(wdq_pkg::OP_PUSH, 16'sh0000);
        send_item(wdq_pkg::OP_PUSH, -16'sd1);
        send_item(wdq_pkg::OP_PUSH, 16'sd1);
        send_item(wdq_pkg::OP_QUERY, 16'sh5555);
        send_item(wdq_pkg::OP_POP_BACK, 16'sh0000);
        send_item(wdq_pkg::OP_POP_FRONT, 16'sh0000);
        send_item(wdq_pkg::OP_PUSH, 16'sh5555);
        send_item(wdq_pkg::OP_PUSH, 16'shaaaa);
        send_item(wdq_pkg::OP_POP_BACK, 16'shffff);
        send_item(wdq_pkg::OP_POP_FRONT, 16'sh0000);
        send_item(wdq_pkg::OP_POP_FRONT, 16'sh0000);
        send_item(wdq_pkg::OP_POP_BACK, 16'sh0000);
        send_item(wdq_pkg::OP_POP_BACK, 16'sh0000);
        send_item(wdq_pkg::OP_POP_FRONT, 16'sh0000);
        send_item(wdq_pkg::OP_QUERY, 16'sh0000);
        wait_for_results();
    endtask

    // Fills the deque to capacity with the largest and then the smallest value,
    // which reaches both ends of the weight range, and pushes once more on each full deque.
    task automatic test_full_extremes();
        in_idle_pct = 53;
        out_stall_pct = 0;
        repeat (wdq_pkg::CAPACITY) send_item(wdq_pkg::OP_PUSH, 16'sh7fff);
        send_item(wdq_pkg::OP_PUSH, 16'sh1234);
        send_item(wdq_pkg::OP_QUERY, 16'sh0000);
        for (int k = 0; k < wdq_pkg::CAPACITY; k++)
            send_item((k % 2 == 0) ? wdq_pkg::OP_POP_BACK : wdq_pkg::OP_POP_FRONT,
                      16'sh0000);
        in_idle_pct = 0;
        out_stall_pct = 53;
        repeat (wdq_pkg::CAPACITY) send_item(wdq_pkg::OP_PUSH, 16'sh8000);
        send_item(wdq_pkg::OP_PUSH, 16'sh7fff);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // input side has to stall; afterwards the sender waits for every result.
    task automatic test_backpressure();
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (16)
            send_item(($urandom_range(1) != 0) ? wdq_pkg::OP_PUSH : wdq_pkg::OP_POP_BACK,
                      pick_value());
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct,
                                       input int push_pct);
        int         r;
        logic [1:0] op;
        in_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 8)
                op = wdq_pkg::OP_QUERY;
            else if (r < 8 + push_pct)
                op = wdq_pkg::OP_PUSH;
            else if ($urandom_range(1) != 0)
                op = wdq_pkg::OP_POP_FRONT;
            else
                op = wdq_pkg::OP_POP_BACK;
            send_item(op, pick_value());
        end
        wait_for_results();
    endtask

    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_extremes();
        test_backpressure();
        test_random_traffic(60, 0, 0, 40);
        test_random_traffic(60, 53, 0, 70);
        test_random_traffic(60, 0, 53, 30);
        test_random_traffic(60, 29, 29, 46);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
